@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of the printer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is asserted.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CHK_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/fsip_pkg.sv @@
// Shared types, constants and helpers of the format string printer core.
package fsip_pkg;

    localparam int DEF_MAX_WIDTH = 63;
    localparam int WIDTH_W       = 6;
    localparam int NUM_DIGITS    = 10;
    localparam int DEC_STEPS     = 32;
    localparam int STEP_W        = $clog2(DEC_STEPS + 1);
    localparam int LEN_W         = $clog2(NUM_DIGITS + 1);
    localparam int DIG_IDX_W     = $clog2(NUM_DIGITS);

    // Format characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_X  = 8'h58;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_C  = 8'h63;
    localparam logic [7:0] CH_LC_D  = 8'h64;
    localparam logic [7:0] CH_LC_U  = 8'h75;
    localparam logic [7:0] CH_LC_X  = 8'h78;

    typedef enum logic [1:0] {
        KIND_CHAR,
        KIND_DEC,
        KIND_HEX
    } t_kind;

    // Controller to datapath
    typedef struct packed {
        logic               pass;   // copy the format byte to the output
        logic               start;  // load an argument word
        logic               step;   // one binary to BCD step
        logic               latch;  // load pad and digit counts
        logic               emit;   // emit one character
        t_kind              kind;
        logic [WIDTH_W-1:0] width;
        logic               left;
        logic               zero;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic conv_done;
        logic emit_last;
    } t_status;

    // Lowercase hex / decimal digit to ASCII
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        if (d > 4'd9) begin
            return CH_LC_A + {4'b0, d - 4'd10};
        end
        return CH_ZERO + {4'b0, d};
    endfunction

endpackage

@@ design/fsip_ctrl.sv @@
// Parser and sequencing state machine of the format string printer core.
module fsip_ctrl
    import fsip_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_op,
    input  logic [7:0] i_byte,
    input  t_status    i_status,
    output t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        P_IDLE,
        P_FLAGS,
        P_WIDTH,
        P_WAIT
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_eng;

    localparam logic [9:0]         MAX_W10 = 10'(MAX_WIDTH);
    localparam logic [WIDTH_W-1:0] MAX_W   = WIDTH_W'(MAX_WIDTH);

    t_phase             r_phase, n_phase;
    t_eng               r_eng, n_eng;
    t_kind              r_kind, n_kind;
    logic               r_left, n_left;
    logic               r_zero, n_zero;
    logic [WIDTH_W-1:0] r_width, n_width;

    logic               w_accept;
    logic               w_start;
    logic               w_pass;
    logic [9:0]         w_wsum;
    logic [WIDTH_W-1:0] w_wsat;

    assign o_in_ready = (r_eng == S_IDLE) && i_status.out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    // Width accumulate, saturating
    assign w_wsum = 10'(r_width) * 10'd10 + {2'b0, i_byte - CH_ZERO};
    assign w_wsat = (w_wsum > MAX_W10) ? MAX_W : w_wsum[WIDTH_W-1:0];

    // Format parser
    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_left  = r_left;
        n_zero  = r_zero;
        n_width = r_width;
        w_start = 1'b0;
        w_pass  = 1'b0;
        if (w_accept) begin
            if (i_op) begin
                if (r_phase == P_WAIT) begin
                    n_phase = P_IDLE;
                    w_start = 1'b1;
                end
            end else if (i_byte == CH_NUL) begin
                n_phase = P_IDLE;
            end else begin
                case (r_phase)
                    P_IDLE: begin
                        if (i_byte == CH_PCT) begin
                            n_left  = 1'b0;
                            n_zero  = 1'b0;
                            n_width = '0;
                            n_phase = P_FLAGS;
                        end else begin
                            w_pass = 1'b1;
                        end
                    end
                    P_FLAGS, P_WIDTH: begin
                        if (r_phase == P_FLAGS && i_byte == CH_MINUS) begin
                            n_left = 1'b1;
                        end else if (r_phase == P_FLAGS && i_byte == CH_ZERO) begin
                            n_zero = 1'b1;
                        end else if (r_phase == P_FLAGS &&
                                     (i_byte == CH_PLUS || i_byte == CH_SPACE ||
                                      i_byte == CH_HASH)) begin
                            // accepted, no effect
                        end else if (i_byte inside {[CH_ONE:CH_NINE]} ||
                                     (r_phase == P_WIDTH && i_byte == CH_ZERO)) begin
                            n_width = w_wsat;
                            n_phase = P_WIDTH;
                        end else begin
                            // conversion letter closes the spec
                            case (i_byte)
                                CH_LC_C: begin
                                    n_kind  = KIND_CHAR;
                                    n_phase = P_WAIT;
                                end
                                CH_LC_D, CH_LC_U: begin
                                    n_kind  = KIND_DEC;
                                    n_phase = P_WAIT;
                                end
                                CH_LC_X, CH_UC_X: begin
                                    n_kind  = KIND_HEX;
                                    n_phase = P_WAIT;
                                end
                                default: begin
                                    n_phase = P_IDLE;
                                end
                            endcase
                        end
                    end
                    default: begin
                        // argument pending: format bytes ignored
                    end
                endcase
            end
        end
    end

    // Conversion and emit sequencing
    always_comb begin
        n_eng       = r_eng;
        o_cmd       = '0;
        o_cmd.pass  = w_pass;
        o_cmd.start = w_start;
        o_cmd.kind  = r_kind;
        o_cmd.width = r_width;
        o_cmd.left  = r_left;
        o_cmd.zero  = r_zero;
        case (r_eng)
            S_IDLE: begin
                if (w_start) begin
                    n_eng = S_CONV;
                end
            end
            S_CONV: begin
                if (i_status.conv_done) begin
                    o_cmd.latch = 1'b1;
                    n_eng       = S_EMIT;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.emit_last) begin
                        n_eng = S_IDLE;
                    end
                end
            end
            default: begin
                n_eng = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_eng   <= S_IDLE;
            r_kind  <= KIND_CHAR;
            r_left  <= 1'b0;
            r_zero  <= 1'b0;
            r_width <= '0;
        end else begin
            r_phase <= n_phase;
            r_eng   <= n_eng;
            r_kind  <= n_kind;
            r_left  <= n_left;
            r_zero  <= n_zero;
            r_width <= n_width;
        end
    end

endmodule

@@ design/fsip_dp.sv @@
// Digit extraction, padding counters and output register of the printer core.
module fsip_dp
    import fsip_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic [7:0]  i_byte,
    input  logic [31:0] i_arg,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_char,
    output logic        o_out_last
);

    logic [31:0]                 r_bin;
    logic [NUM_DIGITS-1:0][3:0]  r_bcd;
    logic [STEP_W-1:0]           r_cnt;
    logic [7:0]                  r_char;
    logic [WIDTH_W-1:0]          r_pad_rem;
    logic [LEN_W-1:0]            r_dig_rem;
    logic                        r_out_valid;
    logic [7:0]                  r_out_char;
    logic                        r_out_last;

    logic [NUM_DIGITS-1:0][3:0]  w_adj;
    logic [LEN_W-1:0]            w_len;
    logic [DIG_IDX_W-1:0]        w_dig_idx;
    logic [7:0]                  w_ch;
    logic                        w_take_pad;
    logic                        w_take_dig;
    logic                        w_last;

    // Add-3 correction on each BCD digit
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            w_adj[i] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
    end

    // Text length: highest nonzero digit, at least one; one for a character
    always_comb begin
        w_len = LEN_W'(1);
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[i] != 4'd0) begin
                w_len = LEN_W'(i + 1);
            end
        end
        if (i_cmd.kind == KIND_CHAR) begin
            w_len = LEN_W'(1);
        end
    end

    // Next character: leading pad, digits, then trailing spaces
    assign w_take_pad = !i_cmd.left && (r_pad_rem != '0);
    assign w_take_dig = !w_take_pad && (r_dig_rem != '0);
    assign w_dig_idx  = DIG_IDX_W'(r_dig_rem - LEN_W'(1));
    assign w_last     = (7'(r_pad_rem) + 7'(r_dig_rem)) == 7'd1;

    always_comb begin
        if (w_take_pad) begin
            w_ch = i_cmd.zero ? CH_ZERO : CH_SPACE;
        end else if (w_take_dig) begin
            w_ch = (i_cmd.kind == KIND_CHAR) ? r_char : digit_char(r_bcd[w_dig_idx]);
        end else begin
            w_ch = CH_SPACE;
        end
    end

    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.conv_done = (r_cnt == '0);
    assign o_status.emit_last = w_last;

    // Conversion and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_pad_rem <= '0;
            r_dig_rem <= '0;
        end else begin
            if (i_cmd.start) begin
                r_char <= i_arg[7:0];
                r_bin  <= i_arg;
                if (i_cmd.kind == KIND_DEC) begin
                    r_bcd <= '0;
                    r_cnt <= STEP_W'(DEC_STEPS);
                end else begin
                    r_bcd <= (NUM_DIGITS * 4)'(i_arg);
                    r_cnt <= '0;
                end
            end else if (i_cmd.step) begin
                r_bcd <= (NUM_DIGITS * 4)'({w_adj, r_bin[31]});
                r_bin <= {r_bin[30:0], 1'b0};
                r_cnt <= r_cnt - STEP_W'(1);
            end
            if (i_cmd.latch) begin
                r_dig_rem <= w_len;
                r_pad_rem <= (i_cmd.width > WIDTH_W'(w_len)) ?
                             i_cmd.width - WIDTH_W'(w_len) : '0;
            end else if (i_cmd.emit) begin
                if (w_take_dig) begin
                    r_dig_rem <= r_dig_rem - LEN_W'(1);
                end else begin
                    r_pad_rem <= r_pad_rem - WIDTH_W'(1);
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.pass) begin
            r_out_valid <= 1'b1;
            r_out_char  <= i_byte;
            r_out_last  <= 1'b1;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
            r_out_char  <= w_ch;
            r_out_last  <= w_last;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

endmodule

@@ design/format_string_integer_printer_core.sv @@
// A plain format byte is in the output register in the cycle after its beat.
// Argument: d/u runs 32 binary-to-BCD steps, c/x load at once; a latch step sets the
// counts, then max(width, digits) characters, one per cycle unless the output stalls.
// Parsing: one item per cycle unless output stalls; an argument holds input off until
// its last char is in the output register. Reset (sync, active low) returns to idle.
module format_string_integer_printer_core
    import fsip_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [7:0] fmt_byte, [39:8] arg_value
    input  logic        s_axis_tuser,   // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_char
    output logic        m_axis_tlast
);

    t_cmd    w_cmd;
    t_status w_status;

    // Parser and sequencer
    fsip_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_op       (s_axis_tuser),
        .i_byte     (s_axis_tdata[7:0]),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Digit unit and output register
    fsip_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_byte      (s_axis_tdata[7:0]),
        .i_arg       (s_axis_tdata[39:8]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_char  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

@@ design/fsip_checker.sv @@
// Port-level checker of the printer core and its bind.
`include "assert_macros.svh"

module fsip_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast
);

    // Output register is empty after reset
    `CHK_ASSERT_NR(a_rst_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

    // Stalled beat holds its payload
    `CHK_ASSERT(a_stall_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled beat changed")

    // Input is only taken when the output register can accept a beat
    `CHK_ASSERT(a_ready_room, i_clk, i_rst_n, s_axis_tready |-> (!m_axis_tvalid || m_axis_tready), "input ready with blocked output")

    // No input while a field is still being emitted
    `CHK_ASSERT(a_busy_emit, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready, "input ready mid field")

endmodule

bind format_string_integer_printer_core fsip_checker u_fsip_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

@@ sim/format_string_integer_printer_core_tb.sv @@
// Self-checking testbench for the format string integer printer core.
`timescale 1ns / 100ps

module format_string_integer_printer_core_tb
    import fsip_pkg::*;
();

    // Item kinds on s_axis_tuser
    localparam logic OP_FMT = 1'b0;
    localparam logic OP_ARG = 1'b1;

    // Spec flag bits
    localparam logic [4:0] F_LEFT  = 5'h01;
    localparam logic [4:0] F_PLUS  = 5'h02;
    localparam logic [4:0] F_SPACE = 5'h04;
    localparam logic [4:0] F_ALT   = 5'h08;
    localparam logic [4:0] F_ZPAD  = 5'h10;

    localparam int TOTAL_ITEMS  = 470;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 64;
    localparam int N_ROWS       = 33;

    typedef enum logic [1:0] {
        SCAN_TEXT,
        SCAN_FLAGS,
        SCAN_WIDTH,
        SCAN_ARG
    } t_scan;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_beat;

    typedef struct {
        logic        op;
        logic [7:0]  fb;
        logic [31:0] arg;
        bit          typed;  // expected text given in the row
        string       txt;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // [7:0] fmt_byte, [39:8] arg_value
    logic        s_axis_tuser;   // [0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] out_char
    logic        m_axis_tlast;

    format_string_integer_printer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Predictor state
    t_scan       scan_state;
    logic [4:0]  flag_bits;
    logic [5:0]  field_w;
    t_kind       arg_kind;
    logic [7:0]  fresh_chars[$];   // characters caused by the latest item

    t_char_beat  text_q[$];        // characters still owed by the core
    t_char_beat  want;

    int fault_count;
    int chars_seen;
    int items_sent;
    int busy_items;                // items that the core does not simply drop
    int args_formatted;
    int quiet_cycles;
    int in_calm;
    int out_calm;

    // Wait before the next beat; occasional runs with no waiting at all
    function automatic int pick_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(8, 40);
        end
        return $urandom_range(0, 15);
    endfunction

    function automatic logic [31:0] pick_arg();
        case ($urandom_range(0, 5))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_digit(logic [7:0] b);
        int w;
        w = int'(field_w) * 10 + int'(b - CH_ZERO);
        field_w = (w > DEF_MAX_WIDTH) ? 6'(DEF_MAX_WIDTH) : 6'(w);
        scan_state = SCAN_WIDTH;
    endfunction

    // Conversion letter: anything else closes the spec silently
    function automatic void close_spec(logic [7:0] b);
        scan_state = SCAN_ARG;
        case (b)
            CH_LC_C:          arg_kind = KIND_CHAR;
            CH_LC_D, CH_LC_U: arg_kind = KIND_DEC;
            CH_LC_X, CH_UC_X: arg_kind = KIND_HEX;
            default:          scan_state = SCAN_TEXT;
        endcase
    endfunction

    // Format the pending argument into fresh_chars
    function automatic void render_arg(logic [31:0] value);
        logic [7:0]  digits[16];
        logic [31:0] v;
        logic [7:0]  pad;
        int          len;
        int          base;
        int          d;
        int          i;
        len = 0;
        if (arg_kind == KIND_CHAR) begin
            digits[0] = value[7:0];
            len = 1;
        end else begin
            base = (arg_kind == KIND_HEX) ? 16 : 10;
            v = value;
            do begin
                d = int'(v % base);
                digits[len] = (d > 9) ? 8'(CH_LC_A + d - 10) : 8'(CH_ZERO + d);
                len++;
                v = v / base;
            end while (v != 0);
        end
        if (int'(field_w) > len && (flag_bits & F_LEFT) != 0) begin
            for (i = len; i > 0; i--) fresh_chars.push_back(digits[i - 1]);
            for (i = len; i < int'(field_w); i++) fresh_chars.push_back(CH_SPACE);
        end else begin
            pad = ((flag_bits & F_ZPAD) != 0) ? CH_ZERO : CH_SPACE;
            for (i = len; i < int'(field_w); i++) fresh_chars.push_back(pad);
            for (i = len; i > 0; i--) fresh_chars.push_back(digits[i - 1]);
        end
    endfunction

    // Advance the format scanner by one item; returns 1 when the item is dropped
    function automatic bit scan_item(logic op, logic [7:0] b, logic [31:0] arg);
        fresh_chars.delete();
        if (op == OP_ARG) begin
            if (scan_state != SCAN_ARG) return 1'b1;
            scan_state = SCAN_TEXT;
            render_arg(arg);
            return 1'b0;
        end
        if (b == CH_NUL) begin
            scan_state = SCAN_TEXT;
            return 1'b0;
        end
        case (scan_state)
            SCAN_TEXT: begin
                if (b == CH_PCT) begin
                    flag_bits  = '0;
                    field_w    = '0;
                    scan_state = SCAN_FLAGS;
                end else begin
                    fresh_chars.push_back(b);
                end
            end
            SCAN_FLAGS: begin
                case (b)
                    CH_MINUS: flag_bits |= F_LEFT;
                    CH_PLUS:  flag_bits |= F_PLUS;
                    CH_SPACE: flag_bits |= F_SPACE;
                    CH_HASH:  flag_bits |= F_ALT;
                    CH_ZERO:  flag_bits |= F_ZPAD;
                    default: begin
                        if (b >= CH_ONE && b <= CH_NINE) push_digit(b);
                        else close_spec(b);
                    end
                endcase
            end
            SCAN_WIDTH: begin
                if (b >= CH_ZERO && b <= CH_NINE) push_digit(b);
                else close_spec(b);
            end
            default: return 1'b1;  // byte while an argument is pending
        endcase
        return 1'b0;
    endfunction

    // Drive one input beat, wait for the handshake, then queue its text
    task automatic send_item(logic op, logic [7:0] fb, logic [31:0] arg,
                             bit typed, string txt);
        int gap;
        int i;
        bit dropped;
        gap = pick_wait(in_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {arg, fb};
        do @(posedge i_clk); while (!s_axis_tready);
        dropped = scan_item(op, fb, arg);
        items_sent++;
        if (!dropped) busy_items++;
        if (!dropped && op == OP_ARG) args_formatted++;
        if (typed) begin
            fresh_chars.delete();
            for (i = 0; i < txt.len(); i++) fresh_chars.push_back(txt[i]);
        end
        for (i = 0; i < fresh_chars.size(); i++) begin
            text_q.push_back('{fresh_chars[i], i == fresh_chars.size() - 1});
        end
    endtask

    // Mostly well-formed specs with random content, some of them broken
    task automatic send_random_spec();
        int         n;
        int         i;
        int         r;
        logic [7:0] b;
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++) begin
            b = 8'($urandom_range(1, 255));
            if (b == CH_PCT) b = CH_HASH;
            send_item(OP_FMT, b, $urandom, 1'b0, "");
        end
        send_item(OP_FMT, CH_PCT, $urandom, 1'b0, "");
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++) begin
            case ($urandom_range(0, 4))
                0:       b = CH_MINUS;
                1:       b = CH_PLUS;
                2:       b = CH_SPACE;
                3:       b = CH_HASH;
                default: b = CH_ZERO;
            endcase
            send_item(OP_FMT, b, $urandom, 1'b0, "");
        end
        // Width: mostly short, now and then three digits to hit saturation
        r = $urandom_range(0, 19);
        n = (r < 6) ? 0 : (r < 16) ? 1 : (r < 19) ? 2 : 3;
        for (i = 0; i < n; i++) begin
            b = (i == 0) ? 8'($urandom_range(CH_ONE, CH_NINE))
                         : 8'($urandom_range(CH_ZERO, CH_NINE));
            send_item(OP_FMT, b, $urandom, 1'b0, "");
        end
        if ($urandom_range(0, 19) == 0) begin
            send_item(OP_FMT, CH_NUL, $urandom, 1'b0, "");
        end
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 4))
                0:       b = "f";
                1:       b = "p";
                2:       b = "s";
                3:       b = CH_PCT;
                default: b = 8'($urandom_range(1, 255));
            endcase
        end else begin
            case ($urandom_range(0, 4))
                0:       b = CH_LC_C;
                1:       b = CH_LC_D;
                2:       b = CH_LC_U;
                3:       b = CH_LC_X;
                default: b = CH_UC_X;
            endcase
        end
        send_item(OP_FMT, b, $urandom, 1'b0, "");
        if ($urandom_range(0, 9) == 0) begin
            send_item(OP_FMT, 8'($urandom_range(1, 255)), $urandom, 1'b0, "");
        end
        send_item(OP_ARG, 8'($urandom), pick_arg(), 1'b0, "");
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Output side: random stalls on tready
    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        out_calm = 0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = pick_wait(out_calm);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Compare each output beat with the oldest expected character
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            chars_seen++;
            if (text_q.size() == 0) begin
                fault_count++;
                $display("[%0t] unexpected beat: expected none, actual char 0x%02h last %0b",
                         $time, m_axis_tdata, m_axis_tlast);
            end else begin
                want = text_q.pop_front();
                if (m_axis_tdata !== want.ch) begin
                    fault_count++;
                    $display("[%0t] out_char mismatch: expected 0x%02h, actual 0x%02h",
                             $time, want.ch, m_axis_tdata);
                end
                if (m_axis_tlast !== want.last) begin
                    fault_count++;
                    $display("[%0t] tlast mismatch on char 0x%02h: expected %0b, actual %0b",
                             $time, want.ch, want.last, m_axis_tlast);
                end
            end
        end
    end

    // Watchdog: cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] timeout: no beat for %0d cycles, %0d chars outstanding",
                     $time, quiet_cycles, text_q.size());
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus
    initial begin
        t_row script[N_ROWS];
        int   k;
        script = '{
            '{OP_FMT, "H",      32'h0,         1'b1, "H"},
            '{OP_ARG, 8'hA5,    32'hFFFF_FFFF, 1'b1, ""},   // stray argument
            '{OP_FMT, CH_PCT,   32'h0,         1'b0, ""},   // left wins over zero, width 63
            '{OP_FMT, CH_MINUS, 32'h0,         1'b0, ""},
            '{OP_FMT, CH_ZERO,  32'h0,         1'b0, ""},
            '{OP_FMT, CH_NINE,  32'h0,         1'b0, ""},
            '{OP_FMT, CH_NINE,  32'h0,         1'b0, ""},
            '{OP_FMT, CH_LC_U,  32'h0,         1'b0, ""},
            '{OP_ARG, 8'h00,    32'hFFFF_FFFF, 1'b0, ""},
            '{OP_FMT, CH_PCT,   32'h0,         1'b0, ""},
            '{OP_FMT, CH_ZERO,  32'h0,         1'b0, ""},
            '{OP_FMT, "8",      32'h0,         1'b0, ""},
            '{OP_FMT, CH_UC_X,  32'h0,         1'b0, ""},
            '{OP_FMT, "Z",      32'h0,         1'b1, ""},   // byte while waiting
            '{OP_ARG, 8'h00,    32'hDEAD_BEEF, 1'b1, "deadbeef"},
            '{OP_FMT, CH_PCT,   32'h0,         1'b0, ""},   // flag after width
            '{OP_FMT, "4",      32'h0,         1'b0, ""},
            '{OP_FMT, CH_PLUS,  32'h0,         1'b1, ""},
            '{OP_FMT, CH_PCT,   32'h0,         1'b0, ""},   // doubled percent
            '{OP_FMT, CH_PCT,   32'h0,         1'b1, ""},
            '{OP_FMT, CH_PCT,   32'h0,         1'b0, ""},   // null byte ends the spec
            '{OP_FMT, "5",      32'h0,         1'b0, ""},
            '{OP_FMT, CH_NUL,   32'h0,         1'b1, ""},
            '{OP_ARG, 8'hFF,    32'h0000_0007, 1'b1, ""},
            '{OP_FMT, CH_PCT,   32'h0,         1'b0, ""},
            '{OP_FMT, CH_LC_C,  32'h0,         1'b0, ""},
            '{OP_ARG, 8'h00,    32'h1234_56FF, 1'b0, ""},
            '{OP_FMT, CH_PCT,   32'h0,         1'b0, ""},
            '{OP_FMT, CH_LC_D,  32'h0,         1'b0, ""},
            '{OP_ARG, 8'h00,    32'h0,         1'b1, "0"},
            '{OP_FMT, CH_PCT,   32'h0,         1'b0, ""},
            '{OP_FMT, CH_LC_X,  32'h0,         1'b0, ""},
            '{OP_ARG, 8'h00,    32'h0000_ABCD, 1'b1, "abcd"}
        };

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_FMT;
        scan_state     = SCAN_TEXT;
        flag_bits      = '0;
        field_w        = '0;
        arg_kind       = KIND_CHAR;
        fault_count    = 0;
        chars_seen     = 0;
        items_sent     = 0;
        busy_items     = 0;
        args_formatted = 0;
        in_calm        = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        for (k = 0; k < N_ROWS; k++) begin
            send_item(script[k].op, script[k].fb, script[k].arg, script[k].typed, script[k].txt);
        end

        // Random specs with some noise beats in between
        while (items_sent < TOTAL_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(1'($urandom), 8'($urandom), $urandom, 1'b0, "");
            end else begin
                send_random_spec();
            end
        end
        s_axis_tvalid <= 1'b0;

        while (text_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d input beats (%0d directed, %0d acted on), %0d arguments formatted,",
                 items_sent, N_ROWS, busy_items, args_formatted);
        $display("%0d output characters checked, %0d mismatches.", chars_seen, fault_count);
        if (fault_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
